// File: rtl/incremental_shuffle_draw_defines.svh
// Assertion macros for the shuffle draw block.
// Each macro expects signals named clk and arst_n in the calling module.
`ifndef INCREMENTAL_SHUFFLE_DRAW_DEFINES_SVH
`define INCREMENTAL_SHUFFLE_DRAW_DEFINES_SVH
`ifndef SYNTHESIS
`define ISD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("shuffle draw check failed");
`define ISD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("shuffle draw check failed");
`else
`define ISD_ASSERT_NOW(label, ante, cons)
`define ISD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/isd_pkg.sv
package isd_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int ENTRY_W     = 10;
	localparam int POS_W       = 11;
	localparam int RND_W       = 32;
	localparam int CFG_W       = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int ST_W        = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LIST_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODE  = 1'b1;

	localparam logic REQ_DRAW = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	localparam logic [ST_W-1:0] ST_OK         = 2'd0;
	localparam logic [ST_W-1:0] ST_ALL_DRAWN  = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_LOADED = 2'd2;

	typedef struct packed {
		logic             req_type;
		logic [RND_W-1:0] random_value;
		logic [POS_W-1:0] new_position;
	} isd_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry_index;
		logic [ST_W-1:0]    status;
	} isd_rsp_t;

	typedef enum logic [1:0] {
		WR_CLR,
		WR_POS,
		WR_OTHER
	} wr_sel_t;

	typedef struct packed {
		logic    set_pos;
		logic    err_out;
		logic    div_start;
		logic    rd_other;
		logic    cap_other;
		logic    cap_a;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    out_ok;
		logic    adv_pos;
		logic    clr_step;
	} isd_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic draw_err;
		logic draw_end;
		logic seq_mode;
	} isd_sts_t;

endpackage

// File: rtl/incremental_shuffle_draw.sv
// Channel   Handshake             Word
// request   start / busy          req: req_type, random_value, new_position
// result    done (one cycle)      rsp: entry_index, status
// config    cfg_we                cfg_index, cfg_wdata
//
// A set request, or a draw at or past the list end or with no list, is handled in the
// idle state; busy stays low. A sequential draw reads the entry at the position and
// answers as it frees the input; a shuffled draw runs the 32-step serial remainder,
// then the two reads and two writes of the swap in the table memory, and answers
// before it frees the input. After reset, busy stays high while all 1024 table
// entries are filled with the identity map. The result strobe cannot be held off.
`include "incremental_shuffle_draw_defines.svh"

module incremental_shuffle_draw (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [isd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [isd_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          start,
	input  isd_pkg::isd_req_t             req,
	output logic                          busy,
	output logic                          done,
	output isd_pkg::isd_rsp_t             rsp
);

	import isd_pkg::*;

	isd_cmd_t cmd;
	isd_sts_t sts;

	isd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.sts      (sts),
		.busy     (busy),
		.cmd      (cmd)
	);

	isd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.rsp       (rsp)
	);

	`ISD_ASSERT_NEXT(a_set_is_silent, start && !busy && req.req_type == REQ_SET, !busy && !done)
	`ISD_ASSERT_NEXT(a_draw_moves_on, start && !busy && req.req_type == REQ_DRAW, busy || done)
	`ISD_ASSERT_NOW(a_fail_index_zero, done && rsp.status != ST_OK, rsp.entry_index == '0)

endmodule

// File: rtl/isd_ram.sv
module isd_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/isd_div.sv
module isd_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [isd_pkg::RND_W-1:0] dividend,
	input  logic [isd_pkg::POS_W-1:0] divisor,
	output logic                     done,
	output logic [isd_pkg::POS_W-1:0] rem
);

	import isd_pkg::*;

	localparam int CNT_W = $clog2(RND_W);

	logic [RND_W-1:0] dvd_q;
	logic [POS_W-1:0] dsr_q;
	logic [POS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [POS_W:0]   trial;
	logic [POS_W:0]   diff;
	logic             fits;

	// One quotient bit per cycle; the remainder stays below the divisor.
	assign trial = {rem_q, dvd_q[RND_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RND_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			rem_q <= fits ? diff[POS_W-1:0] : trial[POS_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: rtl/isd_datapath.sv
module isd_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [isd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [isd_pkg::CFG_W-1:0]     cfg_wdata,
	input  isd_pkg::isd_req_t             req,
	input  isd_pkg::isd_cmd_t             cmd,
	output isd_pkg::isd_sts_t             sts,
	output logic                         done,
	output isd_pkg::isd_rsp_t             rsp
);

	import isd_pkg::*;

	logic [POS_W-1:0]   list_size_q;
	logic               seq_mode_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   other_q;
	logic [ENTRY_W-1:0] a_q;
	logic [IDX_W-1:0]   clr_cnt_q;
	logic               done_q;
	isd_rsp_t           rsp_q;
	logic [POS_W-1:0]   size_eff;
	logic [POS_W-1:0]   rem;
	logic               div_done;
	logic               draw_err;
	logic               draw_end;
	logic [IDX_W-1:0]   raddr;
	logic [IDX_W-1:0]   waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;

	assign size_eff = (list_size_q > POS_W'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES) : list_size_q;
	assign draw_err = (size_eff == '0) || (pos_q > size_eff);
	assign draw_end = (pos_q == size_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_size_q <= '0;
			seq_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LIST_SIZE: list_size_q <= cfg_wdata;
				CFG_SEQ_MODE:  seq_mode_q  <= cfg_wdata[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= cmd.err_out | cmd.out_ok;
			if (cmd.set_pos) begin
				pos_q <= req.new_position;
			end else if (cmd.adv_pos) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_other) begin
			other_q <= pos_q + rem;
		end
		if (cmd.cap_a) begin
			a_q <= rdata;
		end
		if (cmd.err_out) begin
			rsp_q.entry_index <= '0;
			rsp_q.status      <= draw_err ? ST_NOT_LOADED : ST_ALL_DRAWN;
		end else if (cmd.out_ok) begin
			rsp_q.entry_index <= rdata;
			rsp_q.status      <= ST_OK;
		end
	end

	// The divisor is only meaningful when the position is below the size.
	isd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (req.random_value),
		.divisor  (size_eff - pos_q),
		.done     (div_done),
		.rem      (rem)
	);

	assign raddr = cmd.rd_other ? other_q[IDX_W-1:0] : pos_q[IDX_W-1:0];

	always_comb begin
		case (cmd.wr_sel)
			WR_CLR: begin
				waddr = clr_cnt_q;
				wdata = ENTRY_W'(clr_cnt_q);
			end
			WR_POS: begin
				waddr = pos_q[IDX_W-1:0];
				wdata = rdata;
			end
			WR_OTHER: begin
				waddr = other_q[IDX_W-1:0];
				wdata = a_q;
			end
			default: begin
				waddr = clr_cnt_q;
				wdata = ENTRY_W'(clr_cnt_q);
			end
		endcase
	end

	isd_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign sts.clr_last = (clr_cnt_q == IDX_W'(MAX_ENTRIES - 1));
	assign sts.div_done = div_done;
	assign sts.draw_err = draw_err;
	assign sts.draw_end = draw_end;
	assign sts.seq_mode = seq_mode_q;

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: rtl/isd_ctrl.sv
module isd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              req_type,
	input  isd_pkg::isd_sts_t  sts,
	output logic              busy,
	output isd_pkg::isd_cmd_t  cmd
);

	import isd_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_RD_A,
		S_RD_B,
		S_WR_A,
		S_WR_B,
		S_SEQ_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.wr_sel = WR_CLR;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (req_type == REQ_SET) begin
						cmd.set_pos = 1'b1;
					end else if (sts.draw_err || sts.draw_end) begin
						cmd.err_out = 1'b1;
					end else if (sts.seq_mode) begin
						state_d = S_RD_A;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					state_d = S_RD_A;
				end
			end
			S_RD_A: begin
				cmd.cap_other = 1'b1;
				state_d       = sts.seq_mode ? S_SEQ_OUT : S_RD_B;
			end
			S_RD_B: begin
				// Read data now holds the entry at the read position.
				cmd.rd_other = 1'b1;
				cmd.cap_a    = 1'b1;
				state_d      = S_WR_A;
			end
			S_WR_A: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_POS;
				cmd.out_ok = 1'b1;
				state_d    = S_WR_B;
			end
			S_WR_B: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_OTHER;
				cmd.adv_pos = 1'b1;
				state_d     = S_IDLE;
			end
			S_SEQ_OUT: begin
				cmd.out_ok  = 1'b1;
				cmd.adv_pos = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
		end
	end

	assign busy = busy_q;

endmodule

// File: verif/tb.sv
module tb;
	import isd_pkg::*;

	localparam int DRAIN_CYCLES = 48;
	localparam int CYCLE_LIMIT  = 300000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 start     = 1'b0;
	isd_req_t             req       = '0;
	logic                 busy;
	logic                 done;
	isd_rsp_t             rsp;

	isd_req_t pending_reqs[$];
	isd_rsp_t expected_draws[$];

	// Shadow copy of the block state used to predict each draw.
	logic [ENTRY_W-1:0] shadow_perm [MAX_ENTRIES];
	logic [POS_W-1:0]   shadow_pos  = '0;
	logic [CFG_W-1:0]   shadow_size = '0;
	logic               shadow_seq  = 1'b0;

	int mismatches  = 0;
	int cycle_count = 0;
	int burst_left  = 1;
	int gap_left    = 0;

	incremental_shuffle_draw uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.start     (start),
		.req       (req),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Driver: presents the oldest pending word and predicts its result once it is taken.
	always @(posedge clk) begin
		isd_req_t           cur;
		isd_rsp_t           want;
		int unsigned        size_eff;
		int unsigned        pos;
		int unsigned        other;
		int unsigned        rnd;
		int                 r;
		logic [ENTRY_W-1:0] tmp;
		if (start && !busy) begin
			cur = pending_reqs.pop_front();
			if (cur.req_type == REQ_SET) begin
				shadow_pos = cur.new_position;
			end else begin
				size_eff = (shadow_size > MAX_ENTRIES) ? MAX_ENTRIES : shadow_size;
				pos = shadow_pos;
				rnd = cur.random_value;
				want = '0;
				if (size_eff == 0 || pos > size_eff) begin
					want.status = ST_NOT_LOADED;
				end else if (pos == size_eff) begin
					want.status = ST_ALL_DRAWN;
				end else begin
					if (!shadow_seq) begin
						other = pos + rnd % (size_eff - pos);
						tmp = shadow_perm[pos];
						shadow_perm[pos] = shadow_perm[other];
						shadow_perm[other] = tmp;
					end
					want.entry_index = shadow_perm[pos];
					want.status = ST_OK;
					shadow_pos = POS_W'(pos + 1);
				end
				expected_draws = {expected_draws, want};
			end
			if (burst_left > 1) begin
				burst_left = burst_left - 1;
			end else begin
				burst_left = $urandom_range(1, 24);
				r = $urandom_range(0, 9);
				if (r < 3)
					gap_left = 0;
				else if (r < 8)
					gap_left = $urandom_range(1, 8);
				else
					gap_left = $urandom_range(9, 60);
			end
		end
		// A word that was offered but not taken stays on the bus unchanged.
		if (!(start && busy)) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				start <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				start <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every result word is checked against the oldest prediction.
	always @(posedge clk) begin
		isd_rsp_t want;
		if (arst_n && done) begin
			if (expected_draws.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual entry_index=%0d status=%0d",
					$time, rsp.entry_index, rsp.status);
				mismatches++;
			end else begin
				want = expected_draws.pop_front();
				if (rsp.entry_index !== want.entry_index) begin
					$display("%0t: entry_index mismatch, expected %0d, actual %0d",
						$time, want.entry_index, rsp.entry_index);
					mismatches++;
				end
				if (rsp.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, rsp.status);
					mismatches++;
				end
			end
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || start || expected_draws.size() != 0);
		// A set request leaves no result behind, so give the block time to settle.
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_LIST_SIZE)
			shadow_size = value[CFG_W-1:0];
		else
			shadow_seq = value[0];
	endtask

	task automatic configure(input int unsigned size, input int unsigned seq);
		wait_idle();
		write_reg(CFG_LIST_SIZE, size);
		write_reg(CFG_SEQ_MODE, seq);
	endtask

	task automatic push_draw(input logic [RND_W-1:0] rnd);
		isd_req_t w;
		w.req_type = REQ_DRAW;
		w.random_value = rnd;
		w.new_position = POS_W'($urandom_range(0, 2047));
		pending_reqs = {pending_reqs, w};
	endtask

	task automatic push_set(input int unsigned pos);
		isd_req_t w;
		w.req_type = REQ_SET;
		w.random_value = $urandom;
		w.new_position = pos[POS_W-1:0];
		pending_reqs = {pending_reqs, w};
	endtask

	initial begin
		int unsigned size;
		int unsigned seq;
		int          sel;
		int          r;
		for (int i = 0; i < MAX_ENTRIES; i++)
			shadow_perm[i] = ENTRY_W'(i);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Registers still at their reset values: no list is loaded.
		wait_idle();
		push_draw('1);
		push_set(1024);
		push_draw(32'd0);
		push_set(0);

		// A one-entry list drawn to its end and then past it.
		configure(1, 0);
		push_draw(32'd0);
		push_draw('1);
		push_set(2);
		push_draw($urandom);
		push_set(0);

		// An oversized list saturates, walked in order around its end.
		configure(2047, 1);
		push_draw($urandom);
		push_draw($urandom);
		push_set(1023);
		push_draw($urandom);
		push_draw($urandom);
		push_set(1025);
		push_draw($urandom);
		push_set(2047);
		push_draw($urandom);
		push_set(0);

		// Full-size list, shuffled, with the extremes of the random word.
		configure(1024, 0);
		push_draw('1);
		push_draw(32'd0);
		push_set(1023);
		push_draw($urandom);

		for (int ph = 0; ph < 10; ph++) begin
			sel = $urandom_range(0, 9);
			if (sel == 0)
				size = 0;
			else if (sel < 5)
				size = $urandom_range(1, 8);
			else if (sel < 8)
				size = $urandom_range(9, 64);
			else if (sel == 8)
				size = 1024;
			else
				size = $urandom_range(1025, 2047);
			seq = (ph % 3 == 2) ? 1 : 0;
			configure(size, seq);
			for (int n = 0; n < 50; n++) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					push_draw($urandom);
				else if (r < 88)
					push_set($urandom_range(0, size));
				else if (r < 95)
					push_set(0);
				else
					push_set($urandom_range(0, 2047));
			end
		end

		wait_idle();
		if (mismatches == 0 && expected_draws.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
